// ----- sv/xss_pkg.sv -----
`timescale 1ns / 1ps
package xss_pkg;

  localparam int CFG_W    = 17;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SIZE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POPULATION_SIZE = 8'd1;

  localparam logic [63:0] GEN_MULT = 64'h9e3779b97f4a7c13;
  localparam int SHIFT_A = 31;
  localparam int SHIFT_B = 11;
  localparam int SHIFT_C = 30;

  localparam logic REQ_SEED = 1'b0;
  localparam logic REQ_ITEM = 1'b1;

  // One queued request: a seed write or a population item.
  typedef struct packed {
    logic        is_item;
    logic [3:0]  seed_index;
    logic [63:0] seed_word;
    logic [31:0] item_value;
  } entry_t;

endpackage

// ----- sv/xss_if.sv -----
`timescale 1ns / 1ps
interface xss_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [3:0]  seed_index;
  logic [63:0] seed_word;
  logic [31:0] item_value;
  modport source (output valid, req_type, seed_index, seed_word, item_value, input ready);
  modport sink   (input valid, req_type, seed_index, seed_word, item_value, output ready);
endinterface

interface xss_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_value;
  logic [15:0] sample_position;
  logic        sample_complete;
  modport source (output valid, sample_value, sample_position, sample_complete, input ready);
  modport sink   (input valid, sample_value, sample_position, sample_complete, output ready);
endinterface

interface xss_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/xss_front.sv -----
`timescale 1ns / 1ps
module xss_front import xss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [3:0]  in_seed_index,
  input  logic [63:0] in_seed_word,
  input  logic [31:0] in_item_value,
  output logic        head_valid,
  output entry_t      head,
  input  logic        head_pop
);

  entry_t     q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  entry_t     ent;

  always_comb begin
    ent.is_item    = (in_req_type == REQ_ITEM);
    ent.seed_index = in_seed_index;
    ent.seed_word  = in_seed_word;
    ent.item_value = in_item_value;
  end

  assign in_ready   = (count_r != 2'd2);
  assign push       = in_valid && in_ready;
  assign head_valid = (count_r != 2'd0);
  assign head       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = head_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, head_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= ent;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |-> count_r != 2'd0) else $error("queue popped while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !head_pop) |=> count_r == $past(count_r) + 2'd1)
    else $error("queue count missed a push");

endmodule

// ----- sv/xss_div.sv -----
`timescale 1ns / 1ps
module xss_div #(
  parameter int CW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [63:0]   dividend,
  input  logic [CW-1:0] divisor,
  output logic          done,
  output logic [CW-1:0] rem
);

  logic [63:0]   num_r, num_nxt;
  logic [CW-1:0] den_r, den_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW:0]   trial;

  // Restoring division, one quotient bit per cycle; only the remainder is kept.
  assign trial = {rem_r, num_r[63]};

  always_comb begin
    num_r_hold: begin
      num_nxt  = num_r;
      den_nxt  = den_r;
      rem_nxt  = rem_r;
      cnt_nxt  = cnt_r;
      busy_nxt = busy_r;
      done_nxt = 1'b0;
    end
    if (start) begin
      num_nxt  = dividend;
      den_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[62:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = CW'(trial - {1'b0, den_r});
      end else begin
        rem_nxt = trial[CW-1:0];
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < den_r) else $error("remainder not below divisor");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("divider restarted while busy");

endmodule

// ----- sv/xss_back.sv -----
`timescale 1ns / 1ps
module xss_back import xss_pkg::*; #(
  parameter int MAX_POPULATION = 65536,
  parameter int CW = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] sample_size,
  input  logic [CFG_W-1:0] population_size,
  input  logic             head_valid,
  input  entry_t           head,
  output logic             head_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_sample_value,
  output logic [15:0]      out_sample_position,
  output logic             out_sample_complete
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_RDA    = 8'b00000010,
    S_RDB    = 8'b00000100,
    S_MUL0   = 8'b00001000,
    S_MUL1   = 8'b00010000,
    S_MUL2   = 8'b00100000,
    S_DIV    = 8'b01000000,
    S_DECIDE = 8'b10000000
  } state_t;

  localparam logic [31:0] MAX_POP = 32'(MAX_POPULATION);

  state_t        state_r, state_nxt;
  logic [63:0]   words [16];
  logic [15:0]   wvalid_r;
  logic [63:0]   rd_data_r;
  logic          rd_vld_r;
  logic [63:0]   rd_word;
  logic [3:0]    rd_addr;
  logic          we;
  logic [3:0]    wa;
  logic [63:0]   wd;

  logic [3:0]    ptr_r, ptr_nxt;
  logic [CW-1:0] seen_r, seen_nxt;
  logic [CW-1:0] taken_r, taken_nxt;
  logic [CW-1:0] pop_r, pop_nxt;
  logic [CW-1:0] need_r, need_nxt;
  logic [31:0]   item_r, item_nxt;
  logic [63:0]   a_r, a_nxt;
  logic [63:0]   x_r, x_nxt;
  logic [63:0]   p0_r, p0_nxt;
  logic [31:0]   p1_r, p1_nxt;

  logic          ov_r, ov_nxt;
  logic [31:0]   ov_value_r, ov_value_nxt;
  logic [15:0]   ov_pos_r, ov_pos_nxt;
  logic          ov_done_r, ov_done_nxt;

  logic [31:0]   ps32, ss32, pop32, need32;
  logic [CW-1:0] pop_c, need_c, seen_eff, taken_eff, seen_inc;
  logic [63:0]   b1, mixed, prod0, prod1, prod2, u_val;
  logic          div_start, div_done;
  logic [CW-1:0] div_rem, seen_dec;
  logic          selected;

  // Effective population and sample size.
  always_comb begin
    ps32   = {{(32-CFG_W){1'b0}}, population_size};
    ss32   = {{(32-CFG_W){1'b0}}, sample_size};
    pop32  = (ps32 == 32'd0) ? 32'd1 : ((ps32 > MAX_POP) ? MAX_POP : ps32);
    need32 = (ss32 < pop32) ? ss32 : pop32;
    pop_c  = pop32[CW-1:0];
    need_c = need32[CW-1:0];
    // A pass that already ran past a shrunken population restarts first.
    seen_eff  = (seen_r >= pop_c) ? '0 : seen_r;
    taken_eff = (seen_r >= pop_c) ? '0 : taken_r;
    seen_inc  = seen_eff + CW'(1);
    seen_dec  = seen_r + CW'(1);
  end

  assign rd_addr = (state_r == S_RDA) ? ptr_r + 4'd1 : ptr_r;
  assign rd_word = rd_vld_r ? rd_data_r : 64'd0;

  always_comb begin
    b1     = rd_word ^ (rd_word << SHIFT_A);
    mixed  = b1 ^ a_r ^ (b1 >> SHIFT_B) ^ (a_r >> SHIFT_C);
    prod0  = x_r[31:0] * GEN_MULT[31:0];
    prod1  = x_r[31:0] * GEN_MULT[63:32];
    prod2  = x_r[63:32] * GEN_MULT[31:0];
    u_val  = p0_r + {p1_r + prod2[31:0], 32'd0};
  end

  assign selected = (div_rem < (need_r - taken_r));

  always_comb begin
    state_nxt    = state_r;
    ptr_nxt      = ptr_r;
    seen_nxt     = seen_r;
    taken_nxt    = taken_r;
    pop_nxt      = pop_r;
    need_nxt     = need_r;
    item_nxt     = item_r;
    a_nxt        = a_r;
    x_nxt        = x_r;
    p0_nxt       = p0_r;
    p1_nxt       = p1_r;
    ov_nxt       = ov_r && !out_ready;
    ov_value_nxt = ov_value_r;
    ov_pos_nxt   = ov_pos_r;
    ov_done_nxt  = ov_done_r;
    head_pop     = 1'b0;
    we           = 1'b0;
    wa           = head.seed_index;
    wd           = head.seed_word;
    div_start    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (head_valid) begin
          head_pop = 1'b1;
          if (!head.is_item) begin
            we        = 1'b1;
            ptr_nxt   = 4'd0;
            seen_nxt  = '0;
            taken_nxt = '0;
          end else if (taken_eff < need_c) begin
            seen_nxt  = seen_eff;
            taken_nxt = taken_eff;
            pop_nxt   = pop_c;
            need_nxt  = need_c;
            item_nxt  = head.item_value;
            state_nxt = S_RDA;
          end else if (seen_inc >= pop_c) begin
            seen_nxt  = '0;
            taken_nxt = '0;
          end else begin
            seen_nxt  = seen_inc;
            taken_nxt = taken_eff;
          end
        end
      end
      S_RDA: begin
        a_nxt     = rd_word;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        we        = 1'b1;
        wa        = ptr_r + 4'd1;
        wd        = mixed;
        ptr_nxt   = ptr_r + 4'd1;
        x_nxt     = mixed;
        state_nxt = S_MUL0;
      end
      S_MUL0: begin
        p0_nxt    = prod0;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        p1_nxt    = prod1[31:0];
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!ov_r || out_ready) begin
          if (selected) begin
            ov_nxt       = 1'b1;
            ov_value_nxt = item_r;
            ov_pos_nxt   = 16'(taken_r);
            ov_done_nxt  = (taken_r + CW'(1) == need_r);
          end
          if (seen_dec >= pop_r) begin
            seen_nxt  = '0;
            taken_nxt = '0;
          end else begin
            seen_nxt  = seen_dec;
            taken_nxt = selected ? taken_r + CW'(1) : taken_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  xss_div #(.CW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (u_val),
    .divisor  (pop_r - seen_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      words[wa] <= wd;
    end
    rd_data_r <= words[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wvalid_r <= '0;
      rd_vld_r <= 1'b0;
      ptr_r    <= 4'd0;
      seen_r   <= '0;
      taken_r  <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      if (we) begin
        wvalid_r[wa] <= 1'b1;
      end
      rd_vld_r <= wvalid_r[rd_addr];
      ptr_r    <= ptr_nxt;
      seen_r   <= seen_nxt;
      taken_r  <= taken_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pop_r      <= pop_nxt;
    need_r     <= need_nxt;
    item_r     <= item_nxt;
    a_r        <= a_nxt;
    x_r        <= x_nxt;
    p0_r       <= p0_nxt;
    p1_r       <= p1_nxt;
    ov_value_r <= ov_value_nxt;
    ov_pos_r   <= ov_pos_nxt;
    ov_done_r  <= ov_done_nxt;
  end

  assign out_valid           = ov_r;
  assign out_sample_value    = ov_value_r;
  assign out_sample_position = ov_pos_r;
  assign out_sample_complete = ov_done_r;

  a_taken_below_need: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |-> taken_r < need_r) else $error("draw with sample complete");
  a_seen_below_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> seen_r < pop_r) else $error("remaining count is zero");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |-> state_r == S_IDLE) else $error("queue popped while busy");

endmodule

// ----- sv/xorshift_selection_sampler.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Payload
// in_ch     in   req_type, seed_index, seed_word, item_value
// out_ch    out  sample_value, sample_position, sample_complete
// cfg_ch    in   index (0 sample_size, 1 population_size), data
//
// A seed write or a dropped item is taken in the back end's idle step; an item
// that draws a number runs read, multiply and the 64-step remainder unit.
// A two-entry queue takes items while the back end works.
// Reset clears the generator words (via valid bits), the counters, the state
// and output valid; a stalled output holds the back end in its decide step.
module xorshift_selection_sampler import xss_pkg::*; #(
  parameter int MAX_POPULATION = 65536
) (
  input logic    clk,
  input logic    rst_n,
  xss_in_if.sink     in_ch,
  xss_out_if.source  out_ch,
  xss_cfg_if.sink    cfg_ch
);

  localparam int CW = $clog2(MAX_POPULATION + 1);

  logic [CFG_W-1:0] sample_size_r;
  logic [CFG_W-1:0] population_size_r;
  logic             head_valid, head_pop;
  entry_t           head;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_size_r     <= '0;
      population_size_r <= 17'd1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_SAMPLE_SIZE:     sample_size_r     <= cfg_ch.data;
        CFG_POPULATION_SIZE: population_size_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  xss_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_req_type   (in_ch.req_type),
    .in_seed_index (in_ch.seed_index),
    .in_seed_word  (in_ch.seed_word),
    .in_item_value (in_ch.item_value),
    .head_valid    (head_valid),
    .head          (head),
    .head_pop      (head_pop)
  );

  xss_back #(.MAX_POPULATION(MAX_POPULATION), .CW(CW)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .sample_size         (sample_size_r),
    .population_size     (population_size_r),
    .head_valid          (head_valid),
    .head                (head),
    .head_pop            (head_pop),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_sample_value    (out_ch.sample_value),
    .out_sample_position (out_ch.sample_position),
    .out_sample_complete (out_ch.sample_complete)
  );

endmodule

// ----- dv/xss_tb_if.sv -----
`timescale 1ns / 1ps
package xss_tb_pkg;
  import xss_pkg::*;

  typedef struct {
    logic [31:0] value;
    logic [15:0] position;
    logic        complete;
  } sample_t;

  class sample_scoreboard;
    logic [63:0] gen_words[16];
    logic [3:0]  gen_ptr;
    int unsigned seen_cnt;
    int unsigned taken_cnt;
    int unsigned sample_reg;
    int unsigned pop_reg;
    int unsigned max_pop;
    sample_t     pending[$];
    int          errors;
    int          matched;

    function new(int unsigned max_population);
      max_pop = max_population;
      for (int i = 0; i < 16; i++) gen_words[i] = '0;
      gen_ptr = '0;
      seen_cnt = 0;
      taken_cnt = 0;
      sample_reg = 0;
      pop_reg = 1;
      errors = 0;
      matched = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [16:0] data);
      if (idx == CFG_SAMPLE_SIZE) sample_reg = 32'(data);
      else if (idx == CFG_POPULATION_SIZE) pop_reg = 32'(data);
    endfunction

    function logic [63:0] next_random();
      logic [63:0] a;
      logic [63:0] b;
      a = gen_words[gen_ptr];
      gen_ptr = gen_ptr + 4'd1;
      b = gen_words[gen_ptr];
      b = b ^ (b << SHIFT_A);
      gen_words[gen_ptr] = b ^ a ^ (b >> SHIFT_B) ^ (a >> SHIFT_C);
      return gen_words[gen_ptr] * GEN_MULT;
    endfunction

    // Notes one accepted input request: a seed write, or an item and the sample it selects, if any.
    function void note_input(logic req, logic [3:0] sidx, logic [63:0] sword,
                             logic [31:0] val);
      int unsigned pop;
      int unsigned need;
      logic [63:0] draw;
      sample_t     s;
      if (req == REQ_SEED) begin
        gen_words[sidx] = sword;
        gen_ptr = '0;
        seen_cnt = 0;
        taken_cnt = 0;
        return;
      end
      pop = (pop_reg == 0) ? 1 : pop_reg;
      if (pop > max_pop) pop = max_pop;
      need = (sample_reg < pop) ? sample_reg : pop;
      if (seen_cnt >= pop) begin
        seen_cnt = 0;
        taken_cnt = 0;
      end
      if (taken_cnt < need) begin
        draw = next_random() % 64'(pop - seen_cnt);
        if (draw < 64'(need - taken_cnt)) begin
          s.value = val;
          s.position = taken_cnt[15:0];
          s.complete = (taken_cnt + 1 == need);
          pending.push_back(s);
          taken_cnt++;
        end
      end
      seen_cnt++;
      if (seen_cnt >= pop) begin
        seen_cnt = 0;
        taken_cnt = 0;
      end
    endfunction

    function void check_result(logic [31:0] val, logic [15:0] pos, logic done);
      sample_t s;
      if (pending.size() == 0) begin
        $error("unexpected sample: value %h position %0d", val, pos);
        errors++;
        return;
      end
      s = pending.pop_front();
      matched++;
      if (val !== s.value) begin
        $error("sample_value expected %h actual %h", s.value, val);
        errors++;
      end
      if (pos !== s.position) begin
        $error("sample_position expected %0d actual %0d", s.position, pos);
        errors++;
      end
      if (done !== s.complete) begin
        $error("sample_complete expected %0b actual %0b", s.complete, done);
        errors++;
      end
    endfunction
  endclass
endpackage

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import xss_pkg::*;
  import xss_tb_pkg::*;

  localparam int MAX_POP = 65536;
  localparam int TIMEOUT_CYCLES = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  longint unsigned cycle_cnt = 0;
  bit long_stall = 1'b0;

  xss_in_if  in_ch();
  xss_out_if out_ch();
  xss_cfg_if cfg_ch();

  sample_scoreboard sb;

  xorshift_selection_sampler #(.MAX_POPULATION(MAX_POP)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_ITEM;
    in_ch.seed_index = '0;
    in_ch.seed_word = '0;
    in_ch.item_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_SAMPLE_SIZE;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > TIMEOUT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stall pattern, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n || long_stall) out_ch.ready <= 1'b0;
    else if (cycle_cnt[9]) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.sample_value, out_ch.sample_position, out_ch.sample_complete);
  end

  int burst_left = 0;

  // Valid stays high between items of a burst and drops only for a gap.
  task automatic send_item(logic req, logic [3:0] sidx, logic [63:0] sword,
                           logic [31:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.seed_index <= sidx;
    in_ch.seed_word <= sword;
    in_ch.item_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(req, sidx, sword, val);
  endtask

  task automatic send_pop(logic [31:0] val);
    send_item(REQ_ITEM, 4'($urandom), {$urandom, $urandom}, val);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_cfg(logic [7:0] idx, logic [16:0] data);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic seed_all();
    for (int i = 0; i < 16; i++)
      send_item(REQ_SEED, i[3:0], {$urandom, $urandom}, $urandom);
  endtask

  task automatic run_pass(int unsigned n_items);
    for (int unsigned i = 0; i < n_items; i++) send_pop($urandom);
  endtask

  initial begin
    int unsigned pop;
    sb = new(MAX_POP);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset registers select nothing; all-zero generator picks the first items.
    send_pop(32'hFFFF_FFFF);
    write_cfg(CFG_POPULATION_SIZE, 17'd4);
    write_cfg(CFG_SAMPLE_SIZE, 17'd2);
    send_pop(32'h0);
    send_pop(32'hFFFF_FFFF);
    send_pop(32'h1234_5678);
    send_pop(32'h8765_4321);
    // Sample size above population is clamped; population zero acts as one.
    write_cfg(CFG_SAMPLE_SIZE, 17'h1FFFF);
    send_pop(32'hA5A5_A5A5);
    write_cfg(CFG_POPULATION_SIZE, 17'd0);
    send_pop(32'h5A5A_5A5A);
    send_pop(32'h0F0F_0F0F);
    // Population above the maximum saturates.
    write_cfg(CFG_POPULATION_SIZE, 17'h1FFFF);
    send_item(REQ_SEED, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    send_item(REQ_SEED, 4'h0, 64'h0, '0);
    send_item(REQ_SEED, 4'h1, 64'h8000_0000_0000_0001, '0);
    run_pass(3);
    // Overrun: shrink the population while a pass is deep.
    write_cfg(CFG_POPULATION_SIZE, 17'd6);
    write_cfg(CFG_SAMPLE_SIZE, 17'd3);
    run_pass(4);
    write_cfg(CFG_POPULATION_SIZE, 17'd2);
    run_pass(2);

    // Pressure: receiver holds off while items keep arriving.
    write_cfg(CFG_POPULATION_SIZE, 17'd8);
    write_cfg(CFG_SAMPLE_SIZE, 17'd8);
    long_stall = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        long_stall = 1'b0;
      end
      run_pass(12);
    join

    // Random phases, mostly small populations.
    for (int ph = 0; ph < 20; ph++) begin
      pop = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_POP) : $urandom_range(1, 40);
      write_cfg(CFG_POPULATION_SIZE, pop[16:0]);
      case ($urandom_range(0, 3))
        0: write_cfg(CFG_SAMPLE_SIZE, 17'd0);
        1: write_cfg(CFG_SAMPLE_SIZE, 17'h1FFFF);
        default: write_cfg(CFG_SAMPLE_SIZE, 17'($urandom_range(0, pop)));
      endcase
      if ($urandom_range(0, 1)) seed_all();
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 49) == 0)
          send_item(REQ_SEED, 4'($urandom), {$urandom, $urandom}, $urandom);
        else
          send_pop($urandom);
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
